>>> sv/ptt_pkg.sv
// Shared types and constants for the pan/tilt PID tracker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ptt_pkg;

   // Defaults for the top-level parameters.
   localparam int GAIN_FRAC_BITS_DEF = 10;
   localparam int INTEGRAL_WIDTH_DEF = 32;

   // Depth of the command queue and of the result queue.
   localparam int QUEUE_DEPTH = 2;

   // Servo angles in degrees.
   localparam logic [7:0] ANGLE_CENTER = 8'd90;
   localparam logic [7:0] ANGLE_LOW    = 8'd75;
   localparam logic [7:0] ANGLE_HIGH   = 8'd105;
   localparam int         STEP_LIMIT   = 15;

   // Register indexes on the configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P          = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I          = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D          = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEAD_BAND       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOST_TIMEOUT_MS = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCAN_PERIOD_MS  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCAN_PULSE_MS   = 3'd6;

   // Register reset values.
   localparam logic [15:0] GAIN_P_RST          = 16'd819;
   localparam logic [15:0] GAIN_I_RST          = 16'd20;
   localparam logic [15:0] GAIN_D_RST          = 16'd410;
   localparam logic [14:0] DEAD_BAND_RST       = 15'd3;
   localparam logic [15:0] LOST_TIMEOUT_MS_RST = 16'd2000;
   localparam logic [15:0] SCAN_PERIOD_MS_RST  = 16'd600;
   localparam logic [15:0] SCAN_PULSE_MS_RST   = 16'd200;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
   } req_word_type;

   typedef struct packed {
      logic [7:0] yaw_angle;
      logic [7:0] pitch_angle;
      logic       locked;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [14:0] dead_band;
      logic [15:0] lost_timeout_ms;
      logic [15:0] scan_period_ms;
      logic [15:0] scan_pulse_ms;
   } cfg_type;

   // What the front end decided about a word.
   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_IGNORE,
      KIND_DETECT
   } item_kind_type;

   typedef struct packed {
      item_kind_type      kind;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
   } cmd_type;

endpackage

`default_nettype wire

>>> sv/ptt_front.sv
// Front end: accepts request words, classifies them against the dead band
// and holds them in a short command queue. Depends on ptt_pkg.
`default_nettype none

module ptt_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [14:0]           dead_band,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire ptt_pkg::req_word_type req_word,
   output logic                       cmd_valid,
   input  wire logic                  cmd_pop,
   output ptt_pkg::cmd_type           cmd
);
   import ptt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [16:0] mag_x, mag_y;
   logic        do_push, do_pop;
   cmd_type     new_cmd;

   // Magnitudes need 17 bits so that the most negative offset is exact.
   assign mag_x = req_word.offset_x[15] ? 17'(-17'(req_word.offset_x))
                                        : 17'(req_word.offset_x);
   assign mag_y = req_word.offset_y[15] ? 17'(-17'(req_word.offset_y))
                                        : 17'(req_word.offset_y);

   always_comb begin
      new_cmd.offset_x = req_word.offset_x;
      new_cmd.offset_y = req_word.offset_y;
      if (req_word.req_type) begin
         new_cmd.kind = KIND_TICK;
      end else if (mag_x > {2'b00, dead_band} || mag_y > {2'b00, dead_band}) begin
         new_cmd.kind = KIND_DETECT;
      end else begin
         new_cmd.kind = KIND_IGNORE;
      end
   end

   assign req_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

>>> sv/ptt_back.sv
// Back end: runs the PID steps, lock timeout and yaw scan on classified
// commands and produces one result word per command. Depends on ptt_pkg.
`default_nettype none

module ptt_back #(
   parameter int GAIN_FRAC_BITS = ptt_pkg::GAIN_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH = ptt_pkg::INTEGRAL_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ptt_pkg::cfg_type cfg,
   input  wire ptt_pkg::cmd_type cmd,
   input  wire logic             cmd_valid,
   output logic                  cmd_pop,
   input  wire logic             rsp_room,
   output logic                  rsp_push,
   output ptt_pkg::rsp_word_type rsp_word
);
   import ptt_pkg::*;

   localparam int IW    = INTEGRAL_WIDTH;
   localparam int LO_W  = IW / 2;
   localparam int HI_W  = IW - LO_W;
   localparam int PLO_W = LO_W + 18;
   localparam int PHI_W = HI_W + 17;
   localparam int AW    = IW + 18;

   localparam logic signed [IW-1:0] I_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] I_MIN = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [AW-1:0] BIAS  =
      {{(AW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};
   localparam logic signed [AW-1:0] ZERO  = '0;
   localparam logic signed [AW-1:0] Q_MAX = AW'(STEP_LIMIT);
   localparam logic signed [AW-1:0] Q_MIN = -Q_MAX;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   // Tracker state.
   state_type          state_ff, state_in;
   logic signed [IW-1:0] integ_ff [2];
   logic signed [IW-1:0] integ_in [2];
   logic signed [15:0] prev_ff [2];
   logic signed [15:0] prev_in [2];
   logic               lock_ff, lock_in;
   logic [15:0]        since_detect_ff, since_detect_in;
   logic [15:0]        since_scan_ff, since_scan_in;
   logic               scan_right_ff, scan_right_in;
   logic [15:0]        pulse_ff, pulse_in;
   logic [7:0]         yaw_ff, yaw_in;
   logic [7:0]         pitch_ff, pitch_in;

   // PID pipeline, one lane per axis (0 = yaw from x, 1 = pitch from y).
   logic signed [15:0]      e_ff [2];
   logic signed [IW-1:0]    i_ff [2];
   logic signed [16:0]      d_ff [2];
   logic signed [32:0]      pp_ff [2];
   logic signed [33:0]      pd_ff [2];
   logic signed [PLO_W-1:0] pilo_ff [2];
   logic signed [PHI_W-1:0] pihi_ff [2];
   logic signed [AW-1:0]    acc_ff [2];

   logic signed [15:0]      cmd_off [2];
   logic signed [IW:0]      isum [2];
   logic signed [IW-1:0]    isat [2];
   logic signed [16:0]      dnew [2];
   logic signed [32:0]      pp_in [2];
   logic signed [33:0]      pd_in [2];
   logic signed [PLO_W-1:0] pilo_in [2];
   logic signed [PHI_W-1:0] pihi_in [2];
   logic signed [AW-1:0]    acc_in [2];
   logic signed [AW-1:0]    rnd [2];
   logic signed [AW-1:0]    quot [2];
   logic signed [5:0]       step [2];
   logic [7:0]              angle [2];

   // Tick / dead-band path.
   logic        is_tick;
   logic [15:0] sd_n, ss_n, pulse_n;
   logic [7:0]  yaw_n;
   logic        lock_n, scan_n;

   assign cmd_off[0] = cmd.offset_x;
   assign cmd_off[1] = cmd.offset_y;

   for (genvar a = 0; a < 2; a++) begin : g_lane
      assign isum[a] = (IW+1)'(integ_ff[a]) + (IW+1)'(cmd_off[a]);
      assign isat[a] = (isum[a][IW] != isum[a][IW-1])
                       ? (isum[a][IW] ? I_MIN : I_MAX) : isum[a][IW-1:0];
      assign dnew[a] = 17'(cmd_off[a]) - 17'(prev_ff[a]);

      // The integral product is split in two halves to keep each multiplier
      // narrow; the high half is shifted back in during the sum.
      assign pp_in[a]   = $signed({1'b0, cfg.gain_p}) * e_ff[a];
      assign pd_in[a]   = $signed({1'b0, cfg.gain_d}) * d_ff[a];
      assign pilo_in[a] = $signed({1'b0, cfg.gain_i}) * $signed({1'b0, i_ff[a][LO_W-1:0]});
      assign pihi_in[a] = $signed({1'b0, cfg.gain_i}) * $signed(i_ff[a][IW-1:LO_W]);

      assign acc_in[a] = AW'(pp_ff[a]) + AW'(pd_ff[a]) + AW'(pilo_ff[a])
                         + (AW'(pihi_ff[a]) <<< LO_W);

      // Adding the bias before the arithmetic shift truncates toward zero.
      assign rnd[a]  = acc_ff[a] + (acc_ff[a][AW-1] ? BIAS : ZERO);
      assign quot[a] = rnd[a] >>> GAIN_FRAC_BITS;
      assign step[a] = (quot[a] > Q_MAX) ? 6'(STEP_LIMIT)
                     : (quot[a] < Q_MIN) ? -6'(STEP_LIMIT) : quot[a][5:0];
      assign angle[a] = ANGLE_CENTER + {{2{step[a][5]}}, step[a]};
   end

   assign is_tick = (cmd.kind == KIND_TICK);

   always_comb begin
      sd_n    = since_detect_ff;
      ss_n    = since_scan_ff;
      pulse_n = pulse_ff;
      yaw_n   = yaw_ff;
      scan_n  = scan_right_ff;
      if (is_tick) begin
         if (since_detect_ff != '1) begin
            sd_n = since_detect_ff + 1'b1;
         end
         if (since_scan_ff != '1) begin
            ss_n = since_scan_ff + 1'b1;
         end
         if (pulse_ff != '0) begin
            pulse_n = pulse_ff - 1'b1;
            if (pulse_ff == 16'd1) begin
               yaw_n = ANGLE_CENTER;
            end
         end
      end
      lock_n = lock_ff && !(sd_n > cfg.lost_timeout_ms);
      if (!lock_n && ss_n > cfg.scan_period_ms) begin
         ss_n    = '0;
         pulse_n = cfg.scan_pulse_ms;
         if (cfg.scan_pulse_ms == '0) begin
            yaw_n = ANGLE_CENTER;
         end else begin
            yaw_n = scan_right_ff ? ANGLE_HIGH : ANGLE_LOW;
         end
         scan_n = !scan_right_ff;
      end
   end

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid && rsp_room;

   always_comb begin
      state_in        = state_ff;
      integ_in        = integ_ff;
      prev_in         = prev_ff;
      lock_in         = lock_ff;
      since_detect_in = since_detect_ff;
      since_scan_in   = since_scan_ff;
      scan_right_in   = scan_right_ff;
      pulse_in        = pulse_ff;
      yaw_in          = yaw_ff;
      pitch_in        = pitch_ff;
      rsp_push        = 1'b0;
      rsp_word.yaw_angle   = yaw_n;
      rsp_word.pitch_angle = pitch_ff;
      rsp_word.locked      = lock_n;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               unique case (cmd.kind) inside
                  KIND_DETECT: begin
                     integ_in = isat;
                     prev_in  = cmd_off;
                     state_in = ST_MUL;
                  end
                  KIND_TICK, KIND_IGNORE: begin
                     since_detect_in = sd_n;
                     since_scan_in   = ss_n;
                     pulse_in        = pulse_n;
                     yaw_in          = yaw_n;
                     lock_in         = lock_n;
                     scan_right_in   = scan_n;
                     rsp_push        = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // A fresh detection keeps lock, so no scan can start here.
            lock_in         = 1'b1;
            since_detect_in = '0;
            pulse_in        = '0;
            yaw_in          = angle[0];
            pitch_in        = angle[1];
            rsp_push        = 1'b1;
            rsp_word.yaw_angle   = angle[0];
            rsp_word.pitch_angle = angle[1];
            rsp_word.locked      = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         integ_ff        <= '{default: '0};
         prev_ff         <= '{default: '0};
         lock_ff         <= 1'b0;
         since_detect_ff <= '0;
         since_scan_ff   <= '0;
         scan_right_ff   <= 1'b1;
         pulse_ff        <= '0;
         yaw_ff          <= ANGLE_CENTER;
         pitch_ff        <= ANGLE_CENTER;
      end else begin
         state_ff        <= state_in;
         integ_ff        <= integ_in;
         prev_ff         <= prev_in;
         lock_ff         <= lock_in;
         since_detect_ff <= since_detect_in;
         since_scan_ff   <= since_scan_in;
         scan_right_ff   <= scan_right_in;
         pulse_ff        <= pulse_in;
         yaw_ff          <= yaw_in;
         pitch_ff        <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         e_ff <= cmd_off;
         i_ff <= isat;
         d_ff <= dnew;
      end
      pp_ff   <= pp_in;
      pd_ff   <= pd_in;
      pilo_ff <= pilo_in;
      pihi_ff <= pihi_in;
      acc_ff  <= acc_in;
   end

endmodule

`default_nettype wire

>>> sv/ptt_rsp_queue.sv
// Result queue: holds finished result words until the consumer pops them.
// Depends on ptt_pkg.
`default_nettype none

module ptt_rsp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire ptt_pkg::rsp_word_type push_word,
   output logic                       room,
   input  wire logic                  rsp_pop,
   output logic                       rsp_empty,
   output ptt_pkg::rsp_word_type      rsp_word
);
   import ptt_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_word_type     queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign room      = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_word  = queue_ff[rd_ptr_ff];
   assign do_push   = push && room;
   assign do_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

>>> sv/pan_tilt_pid_tracker.sv
// Top level of the pan/tilt PID tracker: configuration registers and the
// front end, back end and result queue. Depends on ptt_pkg and its modules.
//
// Each request word is a one-millisecond tick or a flow measurement, and
// each gives exactly one result word with the yaw and pitch angles and the
// lock flag after that word. The request side takes one word per cycle into
// a two-word command queue until it is full. A tick or a dead-band
// measurement is answered in the same cycle as the back end pops it; a PID
// step passes through error update, multiply, sum, scale and clamp, and no
// new command is popped until it ends, which sets the sustained rate for
// detections. Results wait in a two-word queue, so a stalled consumer does
// not stop work until both queues fill. Configuration writes are always
// taken (csr_ready is high) and should be made while no word is in flight.
`default_nettype none

module pan_tilt_pid_tracker #(
   parameter int GAIN_FRAC_BITS = ptt_pkg::GAIN_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH = ptt_pkg::INTEGRAL_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire ptt_pkg::req_word_type                 req_word,
   output logic                                       rsp_empty,
   input  wire logic                                  rsp_pop,
   output ptt_pkg::rsp_word_type                      rsp_word,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ptt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [15:0]                           csr_data
);
   import ptt_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   cmd_type      cmd;
   logic         cmd_valid, cmd_pop;
   logic         rsp_room, rsp_push;
   rsp_word_type back_word;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_P:          cfg_in.gain_p          = csr_data;
            CSR_GAIN_I:          cfg_in.gain_i          = csr_data;
            CSR_GAIN_D:          cfg_in.gain_d          = csr_data;
            CSR_DEAD_BAND:       cfg_in.dead_band       = csr_data[14:0];
            CSR_LOST_TIMEOUT_MS: cfg_in.lost_timeout_ms = csr_data;
            CSR_SCAN_PERIOD_MS:  cfg_in.scan_period_ms  = csr_data;
            CSR_SCAN_PULSE_MS:   cfg_in.scan_pulse_ms   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p          <= GAIN_P_RST;
         cfg_ff.gain_i          <= GAIN_I_RST;
         cfg_ff.gain_d          <= GAIN_D_RST;
         cfg_ff.dead_band       <= DEAD_BAND_RST;
         cfg_ff.lost_timeout_ms <= LOST_TIMEOUT_MS_RST;
         cfg_ff.scan_period_ms  <= SCAN_PERIOD_MS_RST;
         cfg_ff.scan_pulse_ms   <= SCAN_PULSE_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .dead_band (cfg_ff.dead_band),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   ptt_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push),
      .rsp_word  (back_word)
   );

   ptt_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (back_word),
      .room      (rsp_room),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

>>> sv/ptt_checker.sv
// Port-level checks for the pan/tilt PID tracker, bound to its top level.
// Depends on ptt_pkg and pan_tilt_pid_tracker.
`default_nettype none

module ptt_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_full,
   input wire logic                  rsp_empty,
   input wire logic                  rsp_pop,
   input wire ptt_pkg::rsp_word_type rsp_word
);
   import ptt_pkg::*;

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // A waiting result word that is not popped stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_word))
      else $error("waiting result word changed or vanished");

   // Yaw only ever moves within the clamped servo range.
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.yaw_angle >= ANGLE_LOW && rsp_word.yaw_angle <= ANGLE_HIGH)
      else $error("yaw angle out of range");

   // Pitch is clamped the same way.
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_word.pitch_angle >= ANGLE_LOW
                     && rsp_word.pitch_angle <= ANGLE_HIGH)
      else $error("pitch angle out of range");

endmodule

bind pan_tilt_pid_tracker ptt_checker u_checker (.*);

`default_nettype wire
